[rtl/core/tki_pkg.sv]
// Shared types and constants for the top-k index selector.
// Used by tki_cell and top_k_index_select_core; depends on nothing.
`timescale 1ns / 1ps

package tki_pkg;

   // Fixed field widths
   localparam int SAMPLE_W    = 32;
   localparam int IDX_W       = 10;
   localparam int KEEP_W      = 5;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 5;

   // Default sizing
   localparam int DEF_MAX_K = 16;
   localparam int DEF_MAX_N = 1024;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_KEEP_COUNT     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SELECT_LARGEST = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORDER_BY_VALUE = 2'd2;

   // Register reset values
   localparam logic [KEEP_W-1:0] KEEP_COUNT_RST = 5'd1;

   // Block phases
   typedef enum logic [1:0] {
      PH_COLLECT,
      PH_TRIM,
      PH_SORT,
      PH_EMIT
   } phase_type;

   // What every cell does this cycle
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_TRIM,
      CMD_SORT_EVEN,
      CMD_SORT_ODD,
      CMD_SHIFT_OUT
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         select_largest;
   } cell_ctl_type;

   // Contents of one cell
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] value;
      logic [IDX_W-1:0]           index;
   } cell_type;

   localparam cell_type CELL_EMPTY = '{valid: 1'b0, value: '0, index: '0};

   // Sort key: empty cells order after every valid one
   function automatic logic [IDX_W:0] sort_key(input cell_type c);
      sort_key = {~c.valid, c.index};
   endfunction

endpackage

[rtl/core/tki_cell.sv]
// One cell of the selection chain: holds a value/index pair and trades it
// with its neighbours for insertion, trimming, index sorting and shift-out.
// Depends on tki_pkg.
`timescale 1ns / 1ps

module tki_cell
   import tki_pkg::*;
#(
   parameter int MAX_K = DEF_MAX_K,
   parameter int POS   = 0,
   parameter int KW    = $clog2(MAX_K + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cell_ctl_type               ctl_i,
   input  logic [KW-1:0]              keep_i,
   input  logic signed [SAMPLE_W-1:0] new_value_i,
   input  logic [IDX_W-1:0]           new_index_i,
   input  cell_type                   left_i,
   input  cell_type                   right_i,
   input  logic                       claim_i,
   output logic                       claim_o,
   output cell_type                   cell_o
);

   localparam logic IS_FIRST = (POS == 0);
   localparam logic IS_LAST  = (POS == MAX_K - 1);
   localparam logic POS_ODD  = ((POS % 2) == 1);

   cell_type cell_ff, cell_in;
   logic     better;
   logic     take;
   logic     is_low;
   logic     has_partner;
   logic     swap;

   // Newcomer strictly beats this cell
   always_comb begin
      if (ctl_i.select_largest) begin
         better = new_value_i > cell_ff.value;
      end else begin
         better = new_value_i < cell_ff.value;
      end
   end

   assign take    = ~cell_ff.valid | better;
   assign claim_o = claim_i | take;

   // Odd-even transposition pairing on the index key
   assign is_low      = (POS_ODD == (ctl_i.cmd == CMD_SORT_ODD));
   assign has_partner = is_low ? ~IS_LAST : ~IS_FIRST;
   assign swap        = is_low ? (sort_key(cell_ff) > sort_key(right_i))
                               : (sort_key(left_i) > sort_key(cell_ff));

   // Next cell contents
   always_comb begin
      cell_in = cell_ff;
      case (ctl_i.cmd)
         CMD_INSERT: begin
            if (claim_i) begin
               cell_in = left_i;
            end else if (take) begin
               cell_in.valid = 1'b1;
               cell_in.value = new_value_i;
               cell_in.index = new_index_i;
            end
         end
         CMD_TRIM: begin
            cell_in.valid = cell_ff.valid & (KW'(POS) < keep_i);
         end
         CMD_SORT_EVEN, CMD_SORT_ODD: begin
            if (has_partner && swap) begin
               cell_in = is_low ? right_i : left_i;
            end
         end
         CMD_SHIFT_OUT: begin
            cell_in = right_i;
         end
         default: begin
            cell_in = cell_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;

endmodule

[rtl/core/top_k_index_select_core.sv]
// Top level of the top-k index selector: register port, phase control
// and the chain of tki_cell instances. Depends on tki_pkg and tki_cell.
`timescale 1ns / 1ps

// Samples stream in on req_* at one beat per cycle and are kept, best
// first, in a chain of MAX_K cells; each beat is an insertion that shifts
// the weaker tail down by one cell. Ties keep the earlier sample. The beat
// with tlast set closes the vector: req_tready then drops for the trim
// step, MAX_K odd-even sort passes when ascending index order is chosen
// (none in value order), the emitted beats (one per cycle while rsp_tready
// is high, min(k, kept) of them) and a closing step. Samples past position
// MAX_N-1 are dropped but their tlast still closes the vector.

module top_k_index_select_core
   import tki_pkg::*;
#(
   parameter int MAX_K = DEF_MAX_K,
   parameter int MAX_N = DEF_MAX_N
) (
   input  logic                   clock,
   input  logic                   reset,
   // Sample stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [31:0] sample_value
   input  logic                   req_tlast,   // end_of_vector
   // Index stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [9:0] chosen_index, rest zero
   output logic                   rsp_tlast,   // last_chosen
   // Register writes
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int KW     = $clog2(MAX_K + 1);
   localparam int CMPW   = (KW > KEEP_W) ? KW : KEEP_W;
   localparam int SEEN_W = $clog2(MAX_N + 1);
   localparam int SCW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;

   // Configuration registers
   logic [KEEP_W-1:0] keep_count_ff;
   logic              select_largest_ff;
   logic              order_by_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff     <= KEEP_COUNT_RST;
         select_largest_ff <= 1'b1;
         order_by_value_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_KEEP_COUNT:     keep_count_ff     <= csr_wdata;
            CSR_SELECT_LARGEST: select_largest_ff <= csr_wdata[0];
            CSR_ORDER_BY_VALUE: order_by_value_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // k saturated to the chain length
   logic [KW-1:0] keep_eff;
   assign keep_eff = (CMPW'(keep_count_ff) > CMPW'(MAX_K)) ? KW'(MAX_K)
                                                          : KW'(keep_count_ff);

   // Phase, sample counter and sort pass counter
   phase_type          phase_ff, phase_in;
   logic [SEEN_W-1:0]  seen_ff, seen_in;
   logic [SCW-1:0]     pass_ff, pass_in;
   logic               req_beat;
   logic               rsp_beat;
   logic               room;
   cell_type           cell_q [MAX_K];
   logic [MAX_K:0]     claim;
   logic [MAX_K-1:0]   valid_vec;
   cell_ctl_type       ctl;

   assign req_beat = req_tvalid & req_tready;
   assign rsp_beat = rsp_tvalid & rsp_tready;
   assign room     = seen_ff < SEEN_W'(MAX_N);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_COLLECT: begin
            if (req_beat && req_tlast) begin
               phase_in = PH_TRIM;
            end
         end
         PH_TRIM: begin
            phase_in = order_by_value_ff ? PH_EMIT : PH_SORT;
         end
         PH_SORT: begin
            if (pass_ff == SCW'(MAX_K - 1)) begin
               phase_in = PH_EMIT;
            end
         end
         PH_EMIT: begin
            if (!cell_q[0].valid) begin
               phase_in = PH_COLLECT;
            end
         end
         default: begin
            phase_in = PH_COLLECT;
         end
      endcase
   end

   // Phase outputs: handshakes, cell command and counters
   always_comb begin
      req_tready         = 1'b0;
      rsp_tvalid         = 1'b0;
      ctl.cmd            = CMD_HOLD;
      ctl.select_largest = select_largest_ff;
      seen_in            = seen_ff;
      pass_in            = '0;
      case (phase_ff)
         PH_COLLECT: begin
            req_tready = 1'b1;
            if (req_beat && room) begin
               ctl.cmd = CMD_INSERT;
               seen_in = seen_ff + 1'b1;
            end
         end
         PH_TRIM: begin
            ctl.cmd = CMD_TRIM;
         end
         PH_SORT: begin
            ctl.cmd = pass_ff[0] ? CMD_SORT_ODD : CMD_SORT_EVEN;
            pass_in = pass_ff + 1'b1;
         end
         PH_EMIT: begin
            rsp_tvalid = cell_q[0].valid;
            if (rsp_beat) begin
               ctl.cmd = CMD_SHIFT_OUT;
            end
            if (!cell_q[0].valid) begin
               seen_in = '0;
            end
         end
         default: begin
            ctl.cmd = CMD_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COLLECT;
         seen_ff  <= '0;
         pass_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
         pass_ff  <= pass_in;
      end
   end

   // Cell chain
   assign claim[0] = 1'b0;

   for (genvar p = 0; p < MAX_K; p++) begin : g_cell
      cell_type left_c, right_c;
      if (p == 0) begin : g_head
         assign left_c = CELL_EMPTY;
      end else begin : g_mid_l
         assign left_c = cell_q[p-1];
      end
      if (p == MAX_K - 1) begin : g_tail
         assign right_c = CELL_EMPTY;
      end else begin : g_mid_r
         assign right_c = cell_q[p+1];
      end

      tki_cell #(
         .MAX_K (MAX_K),
         .POS   (p),
         .KW    (KW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl_i       (ctl),
         .keep_i      (keep_eff),
         .new_value_i ($signed(req_tdata[SAMPLE_W-1:0])),
         .new_index_i (IDX_W'(seen_ff)),
         .left_i      (left_c),
         .right_i     (right_c),
         .claim_i     (claim[p]),
         .claim_o     (claim[p+1]),
         .cell_o      (cell_q[p])
      );

      assign valid_vec[p] = cell_q[p].valid;
   end

   // Result beat comes straight from the head cell
   assign rsp_tdata = RSP_TDATA_W'(cell_q[0].index);

   if (MAX_K > 1) begin : g_last_multi
      assign rsp_tlast = ~cell_q[1].valid;
   end else begin : g_last_single
      assign rsp_tlast = 1'b1;
   end

   // Checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("sample and index channels active together");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + 1'b1) & valid_vec) == '0)
      else $error("occupied cells are not a contiguous prefix");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("index beat follows the end of a run");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_W'(MAX_N))
      else $error("sample counter past its limit");

endmodule
